>>> hw/rtl/bsm_pkg.sv
// Shared types and constants for the bank switch mapper.
// No dependencies; imported by every module of the block.
package bsm_pkg;

	typedef enum logic [2:0] {
		CMD_CPU_WR = 3'd0,
		CMD_CPU_RD = 3'd1,
		CMD_CHR_RD = 3'd2,
		CMD_CHR_WR = 3'd3,
		CMD_A12    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_PRG_RAM = 3'd1,
		TGT_PRG_ROM = 3'd2,
		TGT_CHR_ROM = 3'd3,
		TGT_CHR_RAM = 3'd4,
		TGT_ZERO    = 3'd5
	} tgt_t;

	localparam int PRG_OFS_W = 13;   // 8 KiB program bank
	localparam int CHR_OFS_W = 10;   // 1 KiB pattern bank
	localparam int MADDR_W   = 21;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_PRG_ROM_BANKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_RAM_MASK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM    = 2'd2;

	typedef struct packed {
		logic [8:0]  prg_rom_banks;
		logic [12:0] prg_ram_mask;
		logic        chr_is_ram;
	} cfg_t;

	typedef struct packed {
		logic [7:0]      bank_select;   // [7] chr mode, [6] prg mode
		logic [7:0][7:0] bank_regs;
		logic [7:0]      ram_protect;   // [7] enable, [6] write protect
	} map_state_t;

	typedef struct packed {
		logic mirror;
		logic irq;
	} status_t;

	typedef struct packed {
		tgt_t               target;
		logic [MADDR_W-1:0] mem_address;
		logic               mem_write;
		logic [7:0]         write_data;
	} xlat_res_t;

endpackage

>>> hw/rtl/bsm_regs.sv
// Mapper register file, configuration registers and scanline counter.
// Depends on bsm_pkg.
module bsm_regs import bsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  upd,
	input  cmd_t                  cmd,
	input  logic [15:0]           addr,
	input  logic [7:0]            data,
	output cfg_t                  cfg,
	output map_state_t            st,
	output status_t               status_d
);

	logic [8:0]      prg_rom_banks_q;
	logic [12:0]     prg_ram_mask_q;
	logic            chr_is_ram_q;
	logic [7:0]      bank_select_q, bank_select_d;
	logic [7:0][7:0] bank_regs_q, bank_regs_d;
	logic            mirror_q, mirror_d;
	logic [7:0]      ram_protect_q, ram_protect_d;
	logic [7:0]      irq_latch_q, irq_latch_d;
	logic [7:0]      irq_count_q, irq_count_d;
	logic            irq_on_q, irq_on_d;
	logic            irq_pending_q, irq_pending_d;
	logic            last_a12_q, last_a12_d;

	logic [2:0] slot;
	logic [7:0] bank_wdata;
	logic       odd;

	assign odd  = addr[0];
	assign slot = bank_select_q[2:0];

	always_comb begin
		bank_wdata = data;
		if (slot == 3'd6 || slot == 3'd7) begin
			bank_wdata = {2'b00, data[5:0]};
		end else if (slot == 3'd0 || slot == 3'd1) begin
			bank_wdata = {data[7:1], 1'b0};
		end
	end

	always_comb begin
		bank_select_d = bank_select_q;
		bank_regs_d   = bank_regs_q;
		mirror_d      = mirror_q;
		ram_protect_d = ram_protect_q;
		irq_latch_d   = irq_latch_q;
		irq_count_d   = irq_count_q;
		irq_on_d      = irq_on_q;
		irq_pending_d = irq_pending_q;
		last_a12_d    = last_a12_q;
		if (upd && cmd == CMD_CPU_WR && addr[15]) begin
			unique case (addr[14:13])
				2'd0: begin
					if (odd) begin
						bank_regs_d[slot] = bank_wdata;
					end else begin
						bank_select_d = data;
					end
				end
				2'd1: begin
					if (odd) begin
						ram_protect_d = data;
					end else begin
						mirror_d = data[0];
					end
				end
				2'd2: begin
					if (odd) begin
						irq_count_d = 8'd0;
					end else begin
						irq_latch_d = data;
					end
				end
				default: begin
					if (!odd && irq_on_q) begin
						irq_pending_d = 1'b0;
					end
					irq_on_d = odd;
				end
			endcase
		end else if (upd && cmd == CMD_A12) begin
			last_a12_d = addr[12];
			if (!last_a12_q && addr[12]) begin
				if (irq_count_q == 8'd0) begin
					irq_count_d = irq_latch_q;
				end else begin
					irq_count_d = irq_count_q - 8'd1;
					// counter hits zero on this decrement
					if (irq_count_q == 8'd1 && irq_on_q) begin
						irq_pending_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_rom_banks_q <= 9'd2;
			prg_ram_mask_q  <= 13'h1FFF;
			chr_is_ram_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRG_ROM_BANKS: prg_rom_banks_q <= cfg_data[8:0];
				CFG_PRG_RAM_MASK:  prg_ram_mask_q  <= cfg_data;
				CFG_CHR_IS_RAM:    chr_is_ram_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= '0;
			bank_regs_q   <= '0;
			mirror_q      <= 1'b0;
			ram_protect_q <= '0;
			irq_latch_q   <= '0;
			irq_count_q   <= '0;
			irq_on_q      <= 1'b0;
			irq_pending_q <= 1'b0;
			last_a12_q    <= 1'b0;
		end else begin
			bank_select_q <= bank_select_d;
			bank_regs_q   <= bank_regs_d;
			mirror_q      <= mirror_d;
			ram_protect_q <= ram_protect_d;
			irq_latch_q   <= irq_latch_d;
			irq_count_q   <= irq_count_d;
			irq_on_q      <= irq_on_d;
			irq_pending_q <= irq_pending_d;
			last_a12_q    <= last_a12_d;
		end
	end

	assign cfg.prg_rom_banks = prg_rom_banks_q;
	assign cfg.prg_ram_mask  = prg_ram_mask_q;
	assign cfg.chr_is_ram    = chr_is_ram_q;
	assign st.bank_select    = bank_select_q;
	assign st.bank_regs      = bank_regs_q;
	assign st.ram_protect    = ram_protect_q;
	assign status_d.mirror   = mirror_d;
	assign status_d.irq      = irq_pending_d;

`ifndef SYNTH
	a_chr_2k_even: assert property (@(posedge clk) disable iff (!arst_n)
		!bank_regs_q[0][0] && !bank_regs_q[1][0])
		else $error("2 KiB pattern bank register holds an odd bank");

	a_prg_6bit: assert property (@(posedge clk) disable iff (!arst_n)
		bank_regs_q[6][7:6] == 2'b00 && bank_regs_q[7][7:6] == 2'b00)
		else $error("program bank register exceeds 6 bits");

	a_irq_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(irq_pending_q) |-> $past(upd && cmd == CMD_A12 && irq_on_q))
		else $error("irq raised without an A12 edge while enabled");

	a_irq_disable: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(irq_on_q) |-> !irq_pending_q)
		else $error("irq disable left the request pending");
`endif

endmodule

>>> hw/rtl/bsm_xlat.sv
// Address translation: turns one request into a target and memory address.
// Depends on bsm_pkg; purely combinational.
module bsm_xlat import bsm_pkg::*; (
	input  cmd_t        cmd,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	input  cfg_t        cfg,
	input  map_state_t  st,
	output xlat_res_t   res
);

	logic       ram_en, ram_wp, prg_mode;
	logic [7:0] prg_bank;
	logic [12:0] a_chr;
	logic [2:0] chr_slot;
	logic [10:0] chr_ofs;
	logic [MADDR_W-1:0] prg_ram_addr, prg_rom_addr, chr_addr;

	assign ram_en   = st.ram_protect[7];
	assign ram_wp   = st.ram_protect[6];
	assign prg_mode = st.bank_select[6];

	// bank numbers above 8 bits fall off the 21-bit address
	always_comb begin
		unique case (addr[14:13])
			2'd0: prg_bank = prg_mode ? 8'(cfg.prg_rom_banks - 9'd2) : st.bank_regs[6];
			2'd1: prg_bank = st.bank_regs[7];
			2'd2: prg_bank = prg_mode ? st.bank_regs[6] : 8'(cfg.prg_rom_banks - 9'd2);
			default: prg_bank = 8'(cfg.prg_rom_banks - 9'd1);
		endcase
	end

	assign prg_rom_addr = {prg_bank, addr[PRG_OFS_W-1:0]};
	assign prg_ram_addr = {8'd0, addr[12:0] & cfg.prg_ram_mask};

	assign a_chr = addr[12:0] ^ {st.bank_select[7], 12'd0};

	always_comb begin
		if (!a_chr[12]) begin
			chr_slot = {2'b00, a_chr[11]};
			chr_ofs  = addr[10:0];
		end else begin
			chr_slot = 3'd2 + {1'b0, a_chr[11:10]};
			chr_ofs  = {1'b0, addr[9:0]};
		end
	end

	assign chr_addr = {3'd0, st.bank_regs[chr_slot], {CHR_OFS_W{1'b0}}}
		+ {10'd0, chr_ofs};

	always_comb begin
		res.target      = TGT_NONE;
		res.mem_address = '0;
		res.mem_write   = 1'b0;
		res.write_data  = 8'd0;
		unique case (cmd)
			CMD_CPU_WR: begin
				if (!addr[15] && ram_en && !ram_wp) begin
					res.target      = TGT_PRG_RAM;
					res.mem_address = prg_ram_addr;
					res.mem_write   = 1'b1;
					res.write_data  = data;
				end
			end
			CMD_CPU_RD: begin
				if (addr[15]) begin
					res.target      = TGT_PRG_ROM;
					res.mem_address = prg_rom_addr;
				end else if (ram_en) begin
					res.target      = TGT_PRG_RAM;
					res.mem_address = prg_ram_addr;
				end else begin
					res.target = TGT_ZERO;
				end
			end
			CMD_CHR_RD: begin
				res.target      = cfg.chr_is_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
				res.mem_address = chr_addr;
			end
			CMD_CHR_WR: begin
				if (cfg.chr_is_ram) begin
					res.target      = TGT_CHR_RAM;
					res.mem_address = chr_addr;
					res.mem_write   = 1'b1;
					res.write_data  = data;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/bank_switch_mapper_with_scanline_irq.sv
// Bank switch mapper with scanline IRQ. Each request passes through the input
// register and then the result register; one request per cycle sustained while
// m_tready stays high. The result register frees the input side, so
// a new request is taken while a finished result still waits for tready;
// mapper state is updated as a request moves into the result register, so
// each request sees every earlier one. Config writes go straight to the
// registers and belong to idle periods. Depends on bsm_pkg, bsm_regs, bsm_xlat.
module bank_switch_mapper_with_scanline_irq import bsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,    // [15:0] address, [23:16] data
	input  logic [2:0]            s_tuser,    // [2:0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [20:0] mem_address, [21] mem_write, [29:22] write_data,
	// [30] mirroring, [31] irq_line
	output logic [31:0]           m_tdata,
	output logic [2:0]            m_tuser,    // [2:0] target
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic        valid_s2;
	xlat_res_t   res_s2;
	status_t     status_s2;

	logic        adv;
	cfg_t        cfg;
	map_state_t  st;
	status_t     status_d;
	xlat_res_t   res;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= cmd_t'(s_tuser);
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
		end
	end

	bsm_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.upd      (adv),
		.cmd      (cmd_s1),
		.addr     (addr_s1),
		.data     (data_s1),
		.cfg      (cfg),
		.st       (st),
		.status_d (status_d)
	);

	bsm_xlat u_xlat (
		.cmd (cmd_s1),
		.addr(addr_s1),
		.data(data_s1),
		.cfg (cfg),
		.st  (st),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2    <= res;
			status_s2 <= status_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.target;
	assign m_tdata  = {status_s2.irq, status_s2.mirror, res_s2.write_data,
		res_s2.mem_write, res_s2.mem_address};

endmodule

>>> test/bank_switch_mapper_with_scanline_irq_tb.sv
// Self-checking testbench for bank_switch_mapper_with_scanline_irq: directed and random bus
// requests are checked against an in-bench mapper predictor under several cartridge setups.
// Depends on bsm_pkg and the mapper RTL.
module bank_switch_mapper_with_scanline_irq_tb import bsm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam logic [31:0] PRG_BANK = 32'd8192;
	localparam logic [31:0] CHR_BANK = 32'd1024;
	// commands outside the defined set; the mapper must ignore them
	localparam logic [2:0] BAD_CMD_LO = 3'd5;
	localparam logic [2:0] BAD_CMD_HI = 3'd7;

	typedef struct {
		logic [2:0]  cmd;
		logic [15:0] addr;
		logic [7:0]  data;
	} bus_req_t;

	typedef struct {
		tgt_t        target;
		logic [20:0] maddr;
		logic        wr;
		logic [7:0]  wdata;
		logic        mirror;
		logic        irq;
	} xlat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata = '0;    // [15:0] address, [23:16] data
	logic [2:0]            s_tuser = '0;    // [2:0] command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [20:0] mem_address, [21] mem_write, [29:22] write_data, [30] mirroring, [31] irq_line
	logic [31:0]           m_tdata;
	logic [2:0]            m_tuser;         // [2:0] target
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bank_switch_mapper_with_scanline_irq u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// cartridge setup as last written
	logic [8:0]  cfg_rom_banks = 9'd2;
	logic [12:0] cfg_ram_mask = 13'h1FFF;
	logic        cfg_chr_ram = 1'b0;

	// predicted mapper state
	logic [7:0] map_sel = '0;
	logic [7:0] map_bank [8] = '{default: 8'd0};
	logic       map_mirror = 1'b0;
	logic [7:0] map_prot = '0;
	logic [7:0] irq_reload = '0;
	logic [7:0] irq_cnt = '0;
	logic       irq_en = 1'b0;
	logic       irq_flag = 1'b0;
	logic       a12_prev = 1'b0;

	bus_req_t req_q [$];
	xlat_t    xlat_q [$];
	int unsigned n_err = 0;
	logic        idle_en = 1'b1;
	logic        hold_req = 1'b0;
	logic        gen_a12 = 1'b0;

	initial forever #5 clk = ~clk;

	task automatic report(string what, int unsigned want, int unsigned got);
		$display("%0t ns  %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
		n_err++;
	endtask

	function automatic void mapper_reg_write(logic [15:0] a, logic [7:0] d);
		logic [2:0] slot;
		logic [7:0] v;
		slot = map_sel[2:0];
		v = d;
		case (a[14:13])
			2'd0: begin
				if (!a[0]) begin
					map_sel = d;
				end else begin
					if (slot >= 3'd6)
						v = d & 8'h3F;
					else if (slot <= 3'd1)
						v = d & 8'hFE;
					map_bank[slot] = v;
				end
			end
			2'd1: begin
				if (!a[0])
					map_mirror = d[0];
				else
					map_prot = d;
			end
			2'd2: begin
				if (!a[0])
					irq_reload = d;
				else
					irq_cnt = 8'd0;
			end
			default: begin
				// disabling drops a pending interrupt, but only if it was enabled
				if (!a[0] && irq_en)
					irq_flag = 1'b0;
				irq_en = a[0];
			end
		endcase
	endfunction

	function automatic logic [20:0] prg_rom_addr(logic [15:0] a);
		logic [31:0] whole;
		logic [31:0] base;
		logic [31:0] sum;
		whole = cfg_rom_banks * PRG_BANK;
		case (a[14:13])
			2'd0: base = map_sel[6] ? whole - 2 * PRG_BANK : map_bank[6] * PRG_BANK;
			2'd1: base = map_bank[7] * PRG_BANK;
			2'd2: base = map_sel[6] ? map_bank[6] * PRG_BANK : whole - 2 * PRG_BANK;
			default: base = whole - PRG_BANK;
		endcase
		sum = base + a[12:0];
		return sum[20:0];
	endfunction

	function automatic logic [20:0] chr_addr(logic [15:0] a);
		logic [12:0] p;
		logic [2:0]  slot;
		logic [31:0] sum;
		p = a[12:0];
		if (map_sel[7])
			p[12] = ~p[12];
		if (!p[12]) begin
			// 2 KiB banks from the even registers 0 and 1
			slot = p[11] ? 3'd1 : 3'd0;
			sum = map_bank[slot] * CHR_BANK + a[10:0];
		end else begin
			slot = 3'd2 + {1'b0, p[11:10]};
			sum = map_bank[slot] * CHR_BANK + a[9:0];
		end
		return sum[20:0];
	endfunction

	function automatic void a12_update(logic [15:0] a);
		logic rise;
		rise = !a12_prev && a[12];
		a12_prev = a[12];
		if (rise) begin
			if (irq_cnt == 8'd0) begin
				irq_cnt = irq_reload;
			end else begin
				irq_cnt = irq_cnt - 8'd1;
				if (irq_cnt == 8'd0 && irq_en)
					irq_flag = 1'b1;
			end
		end
	endfunction

	function automatic xlat_t map_access(logic [2:0] cmd, logic [15:0] a, logic [7:0] d);
		xlat_t r;
		r.target = TGT_NONE;
		r.maddr = '0;
		r.wr = 1'b0;
		case (cmd)
			CMD_CPU_WR: begin
				if (a[15]) begin
					mapper_reg_write(a, d);
				end else if (map_prot[7] && !map_prot[6]) begin
					r.target = TGT_PRG_RAM;
					r.maddr = {8'd0, a[12:0] & cfg_ram_mask};
					r.wr = 1'b1;
				end
			end
			CMD_CPU_RD: begin
				if (a[15]) begin
					r.target = TGT_PRG_ROM;
					r.maddr = prg_rom_addr(a);
				end else if (map_prot[7]) begin
					r.target = TGT_PRG_RAM;
					r.maddr = {8'd0, a[12:0] & cfg_ram_mask};
				end else begin
					r.target = TGT_ZERO;
				end
			end
			CMD_CHR_RD: begin
				r.target = cfg_chr_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
				r.maddr = chr_addr(a);
			end
			CMD_CHR_WR: begin
				if (cfg_chr_ram) begin
					r.target = TGT_CHR_RAM;
					r.maddr = chr_addr(a);
					r.wr = 1'b1;
				end
			end
			CMD_A12: a12_update(a);
			default: ;
		endcase
		r.wdata = r.wr ? d : 8'd0;
		r.mirror = map_mirror;
		r.irq = irq_flag;
		return r;
	endfunction

	// sender: offers queued requests, with random gaps while idling is on
	always @(posedge clk or negedge arst_n) begin : sender
		bus_req_t r;
		int unsigned gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap = 0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (gap > 0) begin
				gap--;
				s_tvalid <= 1'b0;
			end else if (req_q.size() > 0) begin
				r = req_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {r.data, r.addr};
				s_tuser <= r.cmd;
				if (idle_en && $urandom_range(0, 9) == 0)
					gap = $urandom_range(1, 6);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin : receiver
		int unsigned hold_left;
		int unsigned gap;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			gap = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (gap > 0) begin
			gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (idle_en && $urandom_range(0, 9) == 0)
				gap = $urandom_range(1, 6);
		end
	end

	// monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin : monitor
		xlat_t e;
		if (arst_n && s_tvalid && s_tready)
			xlat_q.push_back(map_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
		if (arst_n && m_tvalid && m_tready) begin
			if (xlat_q.size() == 0) begin
				report("result with nothing outstanding", 0, m_tdata);
			end else begin
				e = xlat_q.pop_front();
				if (m_tuser !== e.target)
					report("target", e.target, m_tuser);
				if (m_tdata[20:0] !== e.maddr)
					report("mem_address", e.maddr, m_tdata[20:0]);
				if (m_tdata[21] !== e.wr)
					report("mem_write", e.wr, m_tdata[21]);
				if (m_tdata[29:22] !== e.wdata)
					report("write_data", e.wdata, m_tdata[29:22]);
				if (m_tdata[30] !== e.mirror)
					report("mirroring", e.mirror, m_tdata[30]);
				if (m_tdata[31] !== e.irq)
					report("irq_line", e.irq, m_tdata[31]);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int unsigned quiet;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", quiet);
			$display("bank_switch_mapper_with_scanline_irq_tb: FAIL");
			$finish;
		end
	end

	task automatic push_req(logic [2:0] cmd, logic [15:0] addr, logic [7:0] data);
		bus_req_t r;
		r.cmd = cmd;
		r.addr = addr;
		r.data = data;
		req_q.push_back(r);
	endtask

	// mostly well-formed mapper traffic: register setup, scanline clocking, accesses
	function automatic bus_req_t rand_req();
		bus_req_t r;
		int unsigned k;
		logic [2:0] kind;
		k = $urandom_range(0, 99);
		r.addr = 16'($urandom);
		r.data = 8'($urandom);
		if (k < 25) begin
			r.cmd = CMD_CPU_WR;
			kind = 3'($urandom_range(0, 7));
			r.addr[15] = 1'b1;
			r.addr[14:13] = kind[2:1];
			r.addr[0] = kind[0];
			if (kind == 3'd4 && $urandom_range(0, 3) != 0)
				r.data = 8'($urandom_range(0, 6));   // short scanline reloads
			if (kind == 3'd3)
				r.data[7] = ($urandom_range(0, 3) != 0);
		end else if (k < 32) begin
			r.cmd = CMD_CPU_WR;
			r.addr[15] = 1'b0;
		end else if (k < 52) begin
			r.cmd = CMD_CPU_RD;
		end else if (k < 65) begin
			r.cmd = CMD_CHR_RD;
		end else if (k < 72) begin
			r.cmd = CMD_CHR_WR;
		end else if (k < 98) begin
			r.cmd = CMD_A12;
			if ($urandom_range(0, 3) != 0)
				gen_a12 = ~gen_a12;
			r.addr[12] = gen_a12;
		end else begin
			r.cmd = 3'($urandom_range(BAD_CMD_LO, BAD_CMD_HI));
		end
		return r;
	endfunction

	// sampled mid-cycle so a request popped at the last edge is already visible
	task automatic wait_drained();
		do @(negedge clk); while (req_q.size() != 0 || s_tvalid || xlat_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic [8:0] banks, logic [12:0] mask, logic chr);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRG_ROM_BANKS;
		cfg_data <= {4'd0, banks};
		cfg_rom_banks = banks;
		@(posedge clk);
		cfg_index <= CFG_PRG_RAM_MASK;
		cfg_data <= mask;
		cfg_ram_mask = mask;
		@(posedge clk);
		cfg_index <= CFG_CHR_IS_RAM;
		cfg_data <= {12'd0, chr};
		cfg_chr_ram = chr;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int unsigned n, logic with_hold);
		repeat (n) req_q.push_back(rand_req());
		if (with_hold)
			hold_req = 1'b1;
		wait_drained();
	endtask

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass under the reset setup
		push_req(CMD_CPU_WR, 16'h8000, 8'hC7);   // both modes, slot 7
		push_req(CMD_CPU_WR, 16'h8001, 8'hFF);   // slot 7 keeps 6 bits
		push_req(CMD_CPU_WR, 16'h8000, 8'h40);
		push_req(CMD_CPU_WR, 16'h8001, 8'hFF);   // slot 0 drops bit 0
		push_req(CMD_CPU_WR, 16'hA000, 8'hFF);
		push_req(CMD_CPU_WR, 16'hA001, 8'h80);   // RAM on, writable
		push_req(CMD_CPU_WR, 16'h7FFF, 8'hA5);
		push_req(CMD_CPU_RD, 16'h0000, 8'h00);
		push_req(CMD_CPU_WR, 16'hA001, 8'hC0);   // write protected
		push_req(CMD_CPU_WR, 16'h6000, 8'h3C);
		push_req(CMD_CPU_WR, 16'hA001, 8'h00);   // RAM off: reads give zero
		push_req(CMD_CPU_RD, 16'h7FFF, 8'h00);
		push_req(CMD_CPU_RD, 16'h8000, 8'h00);
		push_req(CMD_CPU_RD, 16'hBFFF, 8'h00);
		push_req(CMD_CPU_RD, 16'hC000, 8'h00);
		push_req(CMD_CPU_RD, 16'hFFFF, 8'h00);
		push_req(CMD_CHR_RD, 16'h0000, 8'h00);
		push_req(CMD_CHR_RD, 16'hFFFF, 8'h00);
		push_req(CMD_CHR_WR, 16'h1C00, 8'h5A);   // pattern ROM: dropped
		push_req(CMD_CPU_WR, 16'hC000, 8'h01);
		push_req(CMD_CPU_WR, 16'hE001, 8'h00);
		push_req(CMD_A12, 16'h1000, 8'h00);      // counter zero: reload only
		push_req(CMD_A12, 16'h0000, 8'h00);
		push_req(CMD_A12, 16'h1FFF, 8'h00);      // counts down to zero: irq
		push_req(CMD_CPU_WR, 16'hE000, 8'h00);   // disable clears it
		push_req(BAD_CMD_LO, 16'hFFFF, 8'hFF);
		push_req(BAD_CMD_HI, 16'h0000, 8'h00);
		wait_drained();

		set_config(9'd256, 13'd0, 1'b1);
		run_random(150, 1'b1);
		set_config(9'd2, 13'h1FFF, 1'b0);
		run_random(150, 1'b0);
		repeat (4) begin
			set_config(9'($urandom_range(2, 256)), 13'($urandom), 1'($urandom));
			run_random(200, 1'b0);
		end

		// closing stretch at full rate
		idle_en = 1'b0;
		set_config(9'($urandom_range(2, 256)), 13'($urandom), 1'b1);
		run_random(150, 1'b0);

		repeat (10) @(posedge clk);
		if (n_err == 0)
			$display("bank_switch_mapper_with_scanline_irq_tb: PASS");
		else
			$display("bank_switch_mapper_with_scanline_irq_tb: FAIL");
		$finish;
	end

endmodule
